// ----- design/scru_pkg.sv -----
// ----------------------------------------------------------------------------
// scru_pkg
// Shared types, constants and fixed-point helpers of the sine/cosine unit.
// ----------------------------------------------------------------------------
`default_nettype none

package scru_pkg;

  localparam int ANG_W           = 32;
  localparam int OUT_W           = 32;
  localparam int ANGLE_FRAC_BITS = 24;
  localparam int OUT_FRAC_BITS   = 30;
  localparam int FB              = 31;
  localparam int ACC_W           = 60;
  localparam int PHI_W           = ACC_W + 1;
  localparam int PLO_W           = 2 * FB + 1;
  localparam int HORNER_N        = 4;
  localparam int DIV_STEPS       = OUT_FRAC_BITS + 1;
  localparam int FIFO_DEPTH      = 8;
  localparam int FIFO_AW         = $clog2(FIFO_DEPTH);
  localparam int CNT_W           = FIFO_AW + 1;
  // a, y2, horner, num mul (2), abs/den, div init, div steps, output
  localparam int NSTG            = 2 + 2 * HORNER_N + 2 + 1 + 1 + DIV_STEPS + 1;

  localparam logic [31:0] TWO_OVER_PI = 32'hA2F9836E;

  typedef enum logic {
    CMD_SIN = 1'b0,
    CMD_COS = 1'b1
  } scru_cmd_t;

  typedef logic signed [ACC_W-1:0] acc_t;

  localparam acc_t COEF_P [HORNER_N+1] = '{
    60'sd1459688406666,
    -60'sd138472724998245,
    60'sd4401030535375267,
    -60'sd49429081009028442,
    60'sd135788409787737567
  };
  localparam acc_t COEF_Q [HORNER_N+1] = '{
    60'sd10000000000,
    60'sd1326534908786,
    60'sd94630961015382,
    60'sd4081792252343300,
    60'sd86445586529225344
  };

  // reduced item handed from front to back
  typedef struct packed {
    logic [FB:0] y;
    logic        neg;
  } scru_work_t;

  // split product of a fixed-point multiply, before the final sum
  typedef struct packed {
    logic             neg;
    logic [PHI_W-1:0] phi;
    logic [PLO_W-1:0] plo;
  } fxprod_t;

  function automatic logic [ACC_W-1:0] fx_abs(acc_t a);
    return a[ACC_W-1] ? ACC_W'(-a) : ACC_W'(a);
  endfunction

  function automatic fxprod_t fx_mul(acc_t a, logic [FB:0] b);
    logic [ACC_W-1:0] m;
    fxprod_t          p;
    m     = fx_abs(a);
    p.neg = a[ACC_W-1];
    p.phi = PHI_W'(m[ACC_W-1:FB]) * PHI_W'(b);
    p.plo = PLO_W'(m[FB-1:0]) * PLO_W'(b);
    return p;
  endfunction

  function automatic acc_t fx_fin(fxprod_t p, acc_t c);
    logic [PHI_W:0] r;
    acc_t           m;
    r = {1'b0, p.phi} + (PHI_W+1)'(p.plo[PLO_W-1:FB]);
    m = acc_t'(r[ACC_W-1:0]);
    return (p.neg ? -m : m) + c;
  endfunction

endpackage

`default_nettype wire

// ----- design/scru_if.sv -----
// ----------------------------------------------------------------------------
// scru_if
// Valid/ready channel interfaces for the input and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface scru_in_if;
  import scru_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    command;
  logic signed [ANG_W-1:0] angle;
  modport source (output valid, command, angle, input ready);
  modport sink   (input valid, command, angle, output ready);
endinterface

interface scru_out_if;
  import scru_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] value;
  modport source (output valid, value, input ready);
  modport sink   (input valid, value, output ready);
endinterface

`default_nettype wire

// ----- design/scru_front.sv -----
// ----------------------------------------------------------------------------
// scru_front
// Accepts items, takes the angle magnitude, scales by 2/pi and reduces to
// quadrant and fraction. Ready follows queue credit.
// ----------------------------------------------------------------------------
`default_nettype none

module scru_front (
  input  logic                          clk,
  input  logic                          rst_n,
  scru_in_if.sink                       in_chan,
  input  logic [scru_pkg::CNT_W-1:0]    fifo_cnt,
  output logic                          wr_en,
  output scru_pkg::scru_work_t          wr_data
);
  import scru_pkg::*;

  logic              v0_r, v1_r;
  logic [ANG_W-1:0]  mag0_r;
  logic [1:0]        quad0_r, quad1_r;
  logic [1:0]        k1_r;
  logic [FB-1:0]     y1_r;
  logic [63:0]       prod;
  logic [CNT_W:0]    occ;
  logic              acc_in;
  logic [ANG_W:0]    ang_x;
  logic [1:0]        quad;

  assign occ = {1'b0, fifo_cnt} + {{CNT_W{1'b0}}, v0_r} + {{CNT_W{1'b0}}, v1_r};
  assign in_chan.ready = rst_n && (occ < (CNT_W+1)'(FIFO_DEPTH));
  assign acc_in = in_chan.valid && in_chan.ready;
  assign ang_x  = {in_chan.angle[ANG_W-1], in_chan.angle};
  assign prod   = 64'(mag0_r) * 64'(TWO_OVER_PI);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= acc_in;
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in) begin
      mag0_r <= in_chan.angle[ANG_W-1] ? ANG_W'(-ang_x) : ANG_W'(ang_x);
      if (scru_cmd_t'(in_chan.command) == CMD_COS) begin
        quad0_r <= 2'd1;
      end else if (in_chan.angle[ANG_W-1]) begin
        quad0_r <= 2'd2;
      end else begin
        quad0_r <= 2'd0;
      end
    end
    k1_r    <= prod[ANGLE_FRAC_BITS+32 +: 2];
    y1_r    <= prod[ANGLE_FRAC_BITS+32-1 -: FB];
    quad1_r <= quad0_r;
  end

  assign quad         = quad1_r + k1_r;
  assign wr_en        = v1_r;
  assign wr_data.y    = quad[0] ? ((FB+1)'(1) << FB) - {1'b0, y1_r} : {1'b0, y1_r};
  assign wr_data.neg  = quad[1];

endmodule

`default_nettype wire

// ----- design/scru_fifo.sv -----
// ----------------------------------------------------------------------------
// scru_fifo
// Small queue between the reduction front and the evaluation back.
// ----------------------------------------------------------------------------
`default_nettype none

module scru_fifo (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wr_en,
  input  scru_pkg::scru_work_t        wr_data,
  input  logic                        rd_en,
  output scru_pkg::scru_work_t        rd_data,
  output logic                        not_empty,
  output logic [scru_pkg::CNT_W-1:0]  cnt
);
  import scru_pkg::*;

  scru_work_t         mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_r, rp_r;
  logic [CNT_W-1:0]   cnt_r;

  assign cnt       = cnt_r;
  assign not_empty = cnt_r != '0;
  assign rd_data   = mem[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) begin
        wp_r <= wp_r + 1'b1;
      end
      if (rd_en) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + CNT_W'(wr_en) - CNT_W'(rd_en);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (cnt_r < CNT_W'(FIFO_DEPTH) || rd_en))
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> cnt_r != '0)
    else $error("queue underflow");
`endif

endmodule

`default_nettype wire

// ----- design/scru_back.sv -----
// ----------------------------------------------------------------------------
// scru_back
// Evaluates y*P(y^2)/Q(y^2): Horner steps, restoring division one quotient
// bit per stage, rounding, saturation and sign. Whole pipe stalls as one.
// ----------------------------------------------------------------------------
`default_nettype none

module scru_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  scru_pkg::scru_work_t  rd_data,
  input  logic                  not_empty,
  output logic                  rd_en,
  scru_out_if.source            out_chan
);
  import scru_pkg::*;

  logic [NSTG-1:0]  vld_r;
  logic             adv;

  logic [FB:0]      a_y_r, b_y_r, b_y2_r;
  logic             a_neg_r, b_neg_r;
  logic [2*FB+1:0]  ysq;

  fxprod_t          hm_p_r [HORNER_N];
  fxprod_t          hm_q_r [HORNER_N];
  logic [FB:0]      hm_y2_r [HORNER_N];
  logic [FB:0]      hm_y_r [HORNER_N];
  logic             hm_neg_r [HORNER_N];
  acc_t             hs_p_r [HORNER_N];
  acc_t             hs_q_r [HORNER_N];
  logic [FB:0]      hs_y2_r [HORNER_N];
  logic [FB:0]      hs_y_r [HORNER_N];
  logic             hs_neg_r [HORNER_N];
  acc_t             hp_in [HORNER_N];
  acc_t             hq_in [HORNER_N];
  logic [FB:0]      hy2_in [HORNER_N];
  logic [FB:0]      hy_in [HORNER_N];
  logic             hneg_in [HORNER_N];

  fxprod_t          n_m_r;
  acc_t             n_den_r, n_num_r, n_den2_r;
  logic             n_neg_r, n_neg2_r;
  logic [ACC_W-1:0] t_t1_r, t_den_r;
  logic             t_neg_r;

  logic [ACC_W-1:0] dv_rem_r [DIV_STEPS+1];
  logic [ACC_W-1:0] dv_den_r [DIV_STEPS+1];
  logic [FB:0]      dv_q_r [DIV_STEPS+1];
  logic             dv_sat_r [DIV_STEPS+1];
  logic             dv_neg_r [DIV_STEPS+1];

  logic [ACC_W:0]   den2;
  logic [FB+1:0]    rnd;
  logic [OUT_W-1:0] res;
  logic [OUT_W-1:0] out_r;

  assign adv   = !vld_r[NSTG-1] || out_chan.ready;
  assign rd_en = adv && not_empty;
  assign ysq   = (2*FB+2)'(a_y_r) * (2*FB+2)'(a_y_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-2:0], rd_en};
    end
  end

  always_comb begin
    for (int i = 0; i < HORNER_N; i++) begin
      if (i == 0) begin
        hp_in[i]   = COEF_P[0];
        hq_in[i]   = COEF_Q[0];
        hy2_in[i]  = b_y2_r;
        hy_in[i]   = b_y_r;
        hneg_in[i] = b_neg_r;
      end else begin
        hp_in[i]   = hs_p_r[i-1];
        hq_in[i]   = hs_q_r[i-1];
        hy2_in[i]  = hs_y2_r[i-1];
        hy_in[i]   = hs_y_r[i-1];
        hneg_in[i] = hs_neg_r[i-1];
      end
    end
  end

  assign den2 = {t_den_r, 1'b0};

  always_ff @(posedge clk) begin
    if (adv) begin
      a_y_r   <= rd_data.y;
      a_neg_r <= rd_data.neg;
      b_y2_r  <= ysq[2*FB:FB];
      b_y_r   <= a_y_r;
      b_neg_r <= a_neg_r;
      for (int i = 0; i < HORNER_N; i++) begin
        hm_p_r[i]   <= fx_mul(hp_in[i], hy2_in[i]);
        hm_q_r[i]   <= fx_mul(hq_in[i], hy2_in[i]);
        hm_y2_r[i]  <= hy2_in[i];
        hm_y_r[i]   <= hy_in[i];
        hm_neg_r[i] <= hneg_in[i];
        hs_p_r[i]   <= fx_fin(hm_p_r[i], COEF_P[i+1]);
        hs_q_r[i]   <= fx_fin(hm_q_r[i], COEF_Q[i+1]);
        hs_y2_r[i]  <= hm_y2_r[i];
        hs_y_r[i]   <= hm_y_r[i];
        hs_neg_r[i] <= hm_neg_r[i];
      end
      n_m_r    <= fx_mul(hs_p_r[HORNER_N-1], hs_y_r[HORNER_N-1]);
      n_den_r  <= hs_q_r[HORNER_N-1];
      n_neg_r  <= hs_neg_r[HORNER_N-1];
      n_num_r  <= fx_fin(n_m_r, '0);
      n_den2_r <= n_den_r;
      n_neg2_r <= n_neg_r;
      t_t1_r   <= fx_abs(n_num_r);
      t_den_r  <= (n_den2_r == '0) ? ACC_W'(1) : ACC_W'(n_den2_r);
      t_neg_r  <= n_neg2_r;
      // integer part: saturate when two or more, else one quotient bit
      dv_sat_r[0] <= {1'b0, t_t1_r} >= den2;
      dv_den_r[0] <= t_den_r;
      dv_neg_r[0] <= t_neg_r;
      if (t_t1_r >= t_den_r) begin
        dv_rem_r[0] <= t_t1_r - t_den_r;
        dv_q_r[0]   <= (FB+1)'(1);
      end else begin
        dv_rem_r[0] <= t_t1_r;
        dv_q_r[0]   <= '0;
      end
      for (int i = 0; i < DIV_STEPS; i++) begin
        dv_den_r[i+1] <= dv_den_r[i];
        dv_sat_r[i+1] <= dv_sat_r[i];
        dv_neg_r[i+1] <= dv_neg_r[i];
        if ({dv_rem_r[i], 1'b0} >= {1'b0, dv_den_r[i]}) begin
          dv_rem_r[i+1] <= ACC_W'({dv_rem_r[i], 1'b0} - {1'b0, dv_den_r[i]});
          dv_q_r[i+1]   <= {dv_q_r[i][FB-1:0], 1'b1};
        end else begin
          dv_rem_r[i+1] <= {dv_rem_r[i][ACC_W-2:0], 1'b0};
          dv_q_r[i+1]   <= {dv_q_r[i][FB-1:0], 1'b0};
        end
      end
      out_r <= dv_neg_r[DIV_STEPS] ? OUT_W'(-res) : res;
    end
  end

  always_comb begin
    rnd = ({1'b0, dv_q_r[DIV_STEPS]} + (FB+2)'(1)) >> 1;
    if (dv_sat_r[DIV_STEPS] || rnd > (FB+2)'(1) << OUT_FRAC_BITS) begin
      res = OUT_W'(1) << OUT_FRAC_BITS;
    end else begin
      res = OUT_W'(rnd);
    end
  end

  assign out_chan.valid = vld_r[NSTG-1];
  assign out_chan.value = out_r;

`ifndef SYNTHESIS
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> ($signed(out_chan.value) <= $signed(OUT_W'(1) << OUT_FRAC_BITS)
      && $signed(out_chan.value) >= -$signed(OUT_W'(1) << OUT_FRAC_BITS)))
    else $error("result beyond unit range");
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[2*HORNER_N+4] |-> t_den_r != '0)
    else $error("zero divisor in pipe");
  a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> (not_empty && adv))
    else $error("pop without data or while stalled");
`endif

endmodule

`default_nettype wire

// ----- design/sine_cosine_rational_unit_core.sv -----
// ----------------------------------------------------------------------------
// sine_cosine_rational_unit_core
// Sine or cosine of a Q8.24 radian angle, result Q2.30 saturated to +-1.0.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan  : valid/ready item with command (0 sine, 1 cosine) and angle.
//   out_chan : valid/ready item with the signed Q2.30 value.
//   An item is taken when valid and ready are both high at a clock edge.
//   Throughput: one item per cycle when the receiver keeps ready high.
//   Path of an item from the accepting edge to result valid with an empty
//   queue: the accepting edge loads the first of 2 front stages (magnitude,
//   2/pi multiply), then one queue slot and the evaluation pipe of 46 stages
//   (input register, square, four Horner steps of two stages, two-stage
//   numerator multiply, divisor fix, 32 restoring-division stages, rounding
//   and output register).
//   Reset (rst_n low, synchronous) empties the pipes and the queue; the
//   first item may be offered in the cycle after reset is released.
//   When the receiver stalls, the evaluation pipe holds as a whole; the
//   front keeps taking items until the 8-entry queue credit runs out, then
//   drops in_chan.ready.
// ----------------------------------------------------------------------------
`default_nettype none

module sine_cosine_rational_unit_core (
  input  logic        clk,
  input  logic        rst_n,
  scru_in_if.sink     in_chan,
  scru_out_if.source  out_chan
);
  import scru_pkg::*;

  scru_work_t       wr_data, rd_data;
  logic             wr_en, rd_en, not_empty;
  logic [CNT_W-1:0] fifo_cnt;

  scru_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .fifo_cnt (fifo_cnt),
    .wr_en    (wr_en),
    .wr_data  (wr_data)
  );

  scru_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (wr_en),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_data   (rd_data),
    .not_empty (not_empty),
    .cnt       (fifo_cnt)
  );

  scru_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_data   (rd_data),
    .not_empty (not_empty),
    .rd_en     (rd_en),
    .out_chan  (out_chan)
  );

endmodule

`default_nettype wire
